// File: rtl/core/pft_pkg.sv
package pft_pkg;

    localparam int POS_W  = 32;
    localparam int GAP_W  = 33;
    localparam int DIST_W = 33;
    localparam int SQ_W   = 64;
    localparam int REG_W  = 31;

    typedef enum logic [1:0] {
        REG_SMOOTH = 2'd0,
        REG_SPEED  = 2'd1,
        REG_SNAP   = 2'd2,
        REG_DEAD   = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_ROOT,
        ST_DECIDE,
        ST_SPEED,
        ST_SMUL,
        ST_MX,
        ST_DX,
        ST_MY,
        ST_DY,
        ST_APPLY,
        ST_OUT
    } state_t;

    // serial unit control, shared by the multiplier, divider and square root
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } unit_ctl_t;

endpackage

// File: rtl/core/pft_mul.sv
// bit-serial unsigned multiplier: one multiplier bit per cycle
module pft_mul import pft_pkg::*; #(
    parameter int A_W = 64,
    parameter int B_W = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [A_W-1:0]   a,
    input  logic [B_W-1:0]   b,
    output logic [A_W+B_W-1:0] p,
    output unit_ctl_t        ctl
);
    localparam int CW = $clog2(B_W + 1);

    logic [A_W+B_W-1:0] acc_reg, acc_next;
    logic [A_W+B_W-1:0] mcand_reg, mcand_next;
    logic [B_W-1:0]     mplier_reg, mplier_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               busy_reg, busy_next, done_reg, done_next;

    always_comb begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start) begin
            acc_next    = '0;
            mcand_next  = {{B_W{1'b0}}, a};
            mplier_next = b;
            cnt_next    = CW'(B_W);
            busy_next   = 1'b1;
        end else if (busy_reg) begin
            if (mplier_reg[0]) acc_next = acc_reg + mcand_reg;
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign p         = acc_reg;
    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
endmodule

// File: rtl/core/pft_div.sv
// restoring divider, one quotient bit per cycle
module pft_div import pft_pkg::*; #(
    parameter int N_W = 64,
    parameter int D_W = 33
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [N_W-1:0] num,
    input  logic [D_W-1:0] den,
    output logic [N_W-1:0] quo,
    output unit_ctl_t      ctl
);
    localparam int CW = $clog2(N_W + 1);

    logic [N_W-1:0] q_reg, q_next;
    logic [D_W:0]   r_reg, r_next;
    logic [D_W-1:0] d_reg, d_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next, done_reg, done_next;
    logic [D_W:0]   trial;

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[D_W-1:0], q_reg[N_W-1]};
        if (start) begin
            q_next    = num;
            r_next    = '0;
            d_next    = den;
            cnt_next  = CW'(N_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[N_W-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign quo       = q_reg;
    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
endmodule

// File: rtl/core/pft_sqrt.sv
// digit-by-digit integer square root, one result bit per cycle
module pft_sqrt import pft_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [SQ_W-1:0]   rad,
    output logic [SQ_W/2-1:0] root,
    output unit_ctl_t         ctl
);
    localparam int HW = SQ_W / 2;
    localparam int CW = $clog2(HW + 1);

    logic [SQ_W-1:0] v_reg, v_next;
    logic [HW+1:0]   r_reg, r_next;
    logic [HW-1:0]   q_reg, q_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            busy_reg, busy_next, done_reg, done_next;
    logic [HW+1:0]   trial, tst;

    always_comb begin
        v_next    = v_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[HW-1:0], v_reg[SQ_W-1:SQ_W-2]};
        tst       = {q_reg, 2'b01};
        if (start) begin
            v_next    = rad;
            r_next    = '0;
            q_next    = '0;
            cnt_next  = CW'(HW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            v_next = v_reg << 2;
            if (trial >= tst) begin
                r_next = trial - tst;
                q_next = {q_reg[HW-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[HW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        v_reg <= v_next;
        r_reg <= r_next;
        q_reg <= q_next;
    end

    assign root      = q_reg;
    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
endmodule

// File: rtl/core/point_follow_target_step.sv
// Paths from the accepting edge: direct set or snap, dead zone, linear step,
//   smooth step (two 64-bit serial squarings, 32-step root,
//   a 64-bit speed product in smooth mode, then per axis a 64-bit serial multiply
//   and a 128-bit serial divide).
// Throughput: one item at a time; the next beat is taken as soon as the FSM is idle.
// Reset (synchronous, aresetn low): position zero, registers to defaults.
module point_follow_target_step import pft_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [REG_W-1:0]        cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_op,
    input  logic signed [POS_W-1:0] s_target_x,
    input  logic signed [POS_W-1:0] s_target_y,
    input  logic [15:0]             s_time_step,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [POS_W-1:0] m_pos_x,
    output logic signed [POS_W-1:0] m_pos_y,
    output logic                    m_arrived
);
    localparam int LIN_SH = 24 - FRAC_BITS;

    state_t state_reg, state_next;

    logic              smooth_reg;
    logic [15:0]       speed_reg;
    logic [REG_W-1:0]  snap_reg, dead_reg;
    logic signed [POS_W-1:0] px_reg, py_reg;
    logic signed [POS_W-1:0] ox_reg, oy_reg;
    logic              oarr_reg;
    logic [15:0]       dt_reg;
    logic [GAP_W-1:0]  dx_reg, dy_reg;
    logic [POS_W-1:0]  ax_reg, ay_reg;
    logic [SQ_W-1:0]   sum_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [63:0]       step_reg;
    logic [63:0]       mvx_reg;
    logic              arr_reg;
    logic              mval_reg;

    // datapath wires
    logic [GAP_W-1:0]  gdx, gdy;
    logic [GAP_W-1:0]  gax, gay;
    logic              sh;
    logic [DIST_W-1:0] rem_w;
    logic [31:0]       ds_w;
    logic [63:0]       lin_step;
    logic [SQ_W-1:0]   sq_rad;
    logic              out_load;

    // shared units
    logic        mul_start, div_start, sq_start;
    logic [63:0] mul_a, mul_b;
    logic [127:0] mul_p;
    unit_ctl_t   mul_ctl, div_ctl, sq_ctl;
    logic [127:0] div_num;
    logic [127:0] div_q;
    logic [31:0] sq_root;

    pft_mul #(.A_W(64), .B_W(64)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(mul_a), .b(mul_b), .p(mul_p), .ctl(mul_ctl)
    );
    pft_div #(.N_W(128), .D_W(DIST_W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(div_num), .den(dist_reg), .quo(div_q), .ctl(div_ctl)
    );
    pft_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start),
        .rad(sq_rad), .root(sq_root), .ctl(sq_ctl)
    );

    assign gdx = {s_target_x[POS_W-1], s_target_x} - {px_reg[POS_W-1], px_reg};
    assign gdy = {s_target_y[POS_W-1], s_target_y} - {py_reg[POS_W-1], py_reg};
    assign gax = gdx[GAP_W-1] ? (~gdx + 1'b1) : gdx;
    assign gay = gdy[GAP_W-1] ? (~gdy + 1'b1) : gdy;
    assign rem_w = dist_reg - {2'b00, dead_reg};
    assign ds_w  = 32'(dt_reg) * 32'(speed_reg);
    assign lin_step = 64'(ds_w >> LIN_SH);
    // root is started by the done flag of the y square
    assign sq_rad = sum_reg + mul_p[SQ_W-1:0];

    // either gap magnitude at or above 2^31: halve both before squaring
    assign sh = ax_reg[POS_W-1] || ay_reg[POS_W-1];

    assign out_load = (state_reg == ST_OUT) && (!mval_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = s_op ? ST_OUT :
                           ((gax <= {2'b00, snap_reg} && gay <= {2'b00, snap_reg}) ?
                            ST_OUT : ST_SQX);
            ST_SQX:    if (mul_ctl.done) state_next = ST_SQY;
            ST_SQY:    if (mul_ctl.done) state_next = ST_ROOT;
            ST_ROOT:   if (sq_ctl.done) state_next = ST_DECIDE;
            ST_DECIDE: state_next = (dist_reg <= {2'b00, dead_reg}) ? ST_OUT :
                                    (smooth_reg ? ST_SMUL : ST_SPEED);
            ST_SPEED:  state_next = ST_MX;
            ST_SMUL:   if (mul_ctl.done) state_next = ST_MX;
            ST_MX:     if (mul_ctl.done) state_next = ST_DX;
            ST_DX:     if (div_ctl.done) state_next = ST_MY;
            ST_MY:     if (mul_ctl.done) state_next = ST_DY;
            ST_DY:     if (div_ctl.done) state_next = ST_APPLY;
            ST_APPLY:  state_next = ST_OUT;
            ST_OUT:    if (!mval_reg || m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // unit starts: fire on entry to each working state
    always_comb begin
        mul_start = 1'b0;
        div_start = 1'b0;
        sq_start  = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_num   = mul_p;
        unique case (state_reg)
            ST_IDLE: begin
                mul_start = s_valid && !s_op &&
                    !(gax <= {2'b00, snap_reg} && gay <= {2'b00, snap_reg});
                mul_a = 64'((gax[POS_W-1] || gay[POS_W-1]) ? (gax >> 1) : gax);
                mul_b = mul_a;
            end
            ST_SQX: begin
                mul_start = mul_ctl.done;
                mul_a = 64'(sh ? (ay_reg >> 1) : ay_reg);
                mul_b = mul_a;
            end
            ST_SQY: sq_start = mul_ctl.done;
            ST_DECIDE: begin
                mul_start = (dist_reg > {2'b00, dead_reg}) && smooth_reg;
                mul_a = 64'(rem_w);
                mul_b = 64'(ds_w);
            end
            ST_SPEED: begin
                mul_start = 1'b1;
                mul_a = 64'(ax_reg);
                mul_b = (lin_step > 64'(dist_reg)) ? 64'(dist_reg) : lin_step;
            end
            ST_SMUL: begin
                mul_start = mul_ctl.done;
                mul_a = 64'(ax_reg);
                mul_b = (64'(mul_p >> 24) > 64'(dist_reg)) ? 64'(dist_reg)
                                                          : 64'(mul_p >> 24);
            end
            ST_MX: div_start = mul_ctl.done;
            ST_DX: begin
                mul_start = div_ctl.done;
                mul_a = 64'(ay_reg);
                mul_b = step_reg;
            end
            ST_MY: div_start = mul_ctl.done;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            smooth_reg <= 1'b0;
            speed_reg  <= 16'd256;
            snap_reg   <= '0;
            dead_reg   <= '0;
            px_reg     <= '0;
            py_reg     <= '0;
            ox_reg     <= '0;
            oy_reg     <= '0;
            oarr_reg   <= 1'b0;
            mval_reg   <= 1'b0;
            arr_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (reg_idx_t'(cfg_index))
                    REG_SMOOTH: smooth_reg <= cfg_data[0];
                    REG_SPEED:  speed_reg  <= cfg_data[15:0];
                    REG_SNAP:   snap_reg   <= cfg_data;
                    REG_DEAD:   dead_reg   <= cfg_data;
                    default: ;
                endcase
            end
            // result beat is held in its own register so the next item can start
            if (out_load) begin
                mval_reg <= 1'b1;
                ox_reg   <= px_reg;
                oy_reg   <= py_reg;
                oarr_reg <= arr_reg;
            end else if (m_ready) begin
                mval_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: if (s_valid) begin
                    dt_reg <= s_time_step;
                    dx_reg <= gdx;
                    dy_reg <= gdy;
                    ax_reg <= gax[POS_W-1:0];
                    ay_reg <= gay[POS_W-1:0];
                    arr_reg <= 1'b1;
                    if (s_op || (gax <= {2'b00, snap_reg} && gay <= {2'b00, snap_reg})) begin
                        px_reg <= s_target_x;
                        py_reg <= s_target_y;
                    end else begin
                        arr_reg <= 1'b0;
                    end
                end
                ST_SQX: if (mul_ctl.done) sum_reg <= mul_p[SQ_W-1:0];
                ST_SQY: if (mul_ctl.done) sum_reg <= sq_rad;
                ST_ROOT: if (sq_ctl.done)
                    dist_reg <= sh ? {sq_root, 1'b0} : {1'b0, sq_root};
                ST_DECIDE: if (dist_reg <= {2'b00, dead_reg}) arr_reg <= 1'b1;
                ST_SPEED: step_reg <= mul_b;
                ST_SMUL: if (mul_ctl.done) step_reg <= mul_b;
                ST_DX: if (div_ctl.done) mvx_reg <= div_q[63:0];
                ST_APPLY: begin
                    px_reg <= dx_reg[GAP_W-1] ? px_reg - POS_W'(mvx_reg)
                                              : px_reg + POS_W'(mvx_reg);
                    py_reg <= dy_reg[GAP_W-1] ? py_reg - POS_W'(div_q[63:0])
                                              : py_reg + POS_W'(div_q[63:0]);
                end
                default: ;
            endcase
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = mval_reg;
    assign m_pos_x   = ox_reg;
    assign m_pos_y   = oy_reg;
    assign m_arrived = oarr_reg;

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("input taken while busy");
    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_ctl.busy && div_ctl.busy))
        else $error("multiplier and divider overlap");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_pos_x) && $stable(m_pos_y)))
        else $error("result changed while stalled");
`endif
endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import pft_pkg::*;

    localparam int FRAC_BITS  = 16;
    localparam int N_PHASES   = 7;
    localparam int PHASE_ITEMS = 220;
    localparam int CYCLE_LIMIT = 6000000;

    typedef struct {
        bit                    op;
        logic signed [31:0]    tx;
        logic signed [31:0]    ty;
        logic [15:0]           dt;
        bit                    chk;
        logic signed [31:0]    ex;
        logic signed [31:0]    ey;
        bit                    ea;
    } dir_row_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        bit                 arrived;
    } pos_beat_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [1:0]              cfg_index = '0;
    logic [REG_W-1:0]        cfg_data = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic                    s_op = 1'b0;
    logic signed [31:0]      s_target_x = '0;
    logic signed [31:0]      s_target_y = '0;
    logic [15:0]             s_time_step = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [31:0]      m_pos_x;
    logic signed [31:0]      m_pos_y;
    logic                    m_arrived;

    // predictor state
    logic signed [31:0] trk_x, trk_y;
    bit                 cfg_smooth;
    logic [15:0]        cfg_speed;
    logic [30:0]        cfg_snap;
    logic [30:0]        cfg_dead;

    pos_beat_t pos_expect_q[$];
    dir_row_t  dir_rows[$];
    int        errors = 0;
    int        n_results = 0;
    int        n_arrived = 0;
    int        cycles = 0;
    int        ready_stall = 0;
    bit        no_idle = 0;

    point_follow_target_step #(.FRAC_BITS(FRAC_BITS)) dut (.*);

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned r, t;
        r = 0;
        for (int i = 31; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    // sign(gap) * floor(|gap| * step / span), wide intermediate
    function automatic longint axis_shift(longint gap, longint unsigned stp,
                                         longint unsigned span);
        longint unsigned mag;
        logic [127:0] wide;
        mag = (gap < 0) ? longint'(-gap) : gap;
        wide = ({64'd0, mag} * {64'd0, stp}) / {64'd0, span};
        return (gap < 0) ? -longint'(wide[63:0]) : longint'(wide[63:0]);
    endfunction

    function automatic pos_beat_t follow_step(bit op, logic signed [31:0] tx,
                                              logic signed [31:0] ty, logic [15:0] dt);
        pos_beat_t r;
        longint gx, gy;
        longint unsigned ax, ay, a, b, span, rem, ds, stp;
        int sh;
        logic [127:0] wide;
        r.arrived = 0;
        if (op) begin
            trk_x = tx;
            trk_y = ty;
            r.arrived = 1;
        end else begin
            gx = longint'(tx) - longint'(trk_x);
            gy = longint'(ty) - longint'(trk_y);
            ax = (gx < 0) ? -gx : gx;
            ay = (gy < 0) ? -gy : gy;
            if (ax <= cfg_snap && ay <= cfg_snap) begin
                trk_x = tx;
                trk_y = ty;
                r.arrived = 1;
            end else begin
                sh = (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) ? 1 : 0;
                a = ax >> sh;
                b = ay >> sh;
                span = root64(a * a + b * b) << sh;
                if (span <= cfg_dead) begin
                    r.arrived = 1;
                end else begin
                    rem = span - cfg_dead;
                    ds = longint'(dt) * longint'(cfg_speed);
                    if (cfg_smooth) begin
                        wide = {64'd0, rem} * {64'd0, ds};
                        stp = wide[87:24];
                    end else begin
                        stp = ds >> (24 - FRAC_BITS);
                    end
                    if (stp > span) stp = span;
                    trk_x = 32'(longint'(trk_x) + axis_shift(gx, stp, span));
                    trk_y = 32'(longint'(trk_y) + axis_shift(gy, stp, span));
                end
            end
        end
        r.x = trk_x;
        r.y = trk_y;
        return r;
    endfunction

    // result side: compare each beat against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            ready_stall = no_idle ? 0 : $urandom_range(0, 9);
            n_results++;
            if (m_arrived) n_arrived++;
            if (pos_expect_q.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                pos_beat_t e;
                e = pos_expect_q.pop_front();
                if (m_pos_x !== e.x) begin
                    $error("pos_x expected %h got %h", e.x, m_pos_x);
                    errors++;
                end
                if (m_pos_y !== e.y) begin
                    $error("pos_y expected %h got %h", e.y, m_pos_y);
                    errors++;
                end
                if (m_arrived !== e.arrived) begin
                    $error("arrived expected %0d got %0d", e.arrived, m_arrived);
                    errors++;
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (ready_stall > 0) begin
            m_ready <= 1'b0;
            ready_stall--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic cfg_write(reg_idx_t idx, logic [30:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            REG_SMOOTH: cfg_smooth = val[0];
            REG_SPEED:  cfg_speed = val[15:0];
            REG_SNAP:   cfg_snap = val;
            REG_DEAD:   cfg_dead = val;
        endcase
    endtask

    // called at a falling edge; returns at a falling edge after the beat is taken
    task automatic send_item(bit op, logic signed [31:0] tx, logic signed [31:0] ty,
                             logic [15:0] dt, output pos_beat_t got);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_op = op;
        s_target_x = tx;
        s_target_y = ty;
        s_time_step = dt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        got = follow_step(op, tx, ty, dt);
        pos_expect_q.push_back(got);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic add_row(bit op, logic [31:0] tx, logic [31:0] ty, logic [15:0] dt,
                           bit chk, logic [31:0] ex = 0, logic [31:0] ey = 0, bit ea = 0);
        dir_row_t r;
        r.op = op; r.tx = tx; r.ty = ty; r.dt = dt;
        r.chk = chk; r.ex = ex; r.ey = ey; r.ea = ea;
        dir_rows.push_back(r);
    endtask

    task automatic drain();
        while (pos_expect_q.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    initial begin
        pos_beat_t       got;
        logic [31:0]     cfg_tab[N_PHASES][4];
        logic signed [31:0] tx, ty;
        logic [15:0]     dt;
        bit              op;
        int              pick, k;

        trk_x = 0; trk_y = 0;
        cfg_smooth = 0; cfg_speed = 16'd256; cfg_snap = 0; cfg_dead = 0;

        // reset defaults: linear, unit speed, no snap, no dead zone
        add_row(0, 32'h0, 32'h0, 16'd100, 1, 32'h0, 32'h0, 1);            // zero gap snaps
        add_row(1, 32'h7FFF_FFFF, 32'h8000_0000, 16'd5, 1,
                32'h7FFF_FFFF, 32'h8000_0000, 1);                          // direct set
        add_row(0, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0, 1,
                32'h7FFF_FFFF, 32'h8000_0000, 1);
        add_row(0, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0, 1,
                32'h7FFF_FFFF, 32'h8000_0000, 0);                          // zero time
        add_row(0, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 0);            // widest gap
        add_row(1, 32'h0, 32'h0, 16'hFFFF, 1, 32'h0, 32'h0, 1);
        add_row(0, 32'h0001_0000, 32'h0, 16'h8000, 0);
        add_row(0, -32'sd5, 32'd3, 16'hFFFF, 0);                          // step clamped
        add_row(0, 32'h1234_5678, -32'sh0234_5678, 16'h1234, 0);
        add_row(1, 32'hFFFF_FFFF, 32'h1, 16'h0, 1, 32'hFFFF_FFFF, 32'h1, 1);
        add_row(0, 32'h8000_0000, 32'h8000_0000, 16'h0001, 0);

        cfg_tab[0] = '{0, 256, 0, 0};
        cfg_tab[1] = '{0, 65535, 0, 0};
        cfg_tab[2] = '{1, 256, 32'h1_0000, 32'h800};
        cfg_tab[3] = '{1, 65535, 0, 32'h7FFF_FFFF};
        cfg_tab[4] = '{0, 0, 32'h7FFF_FFFF, 0};
        cfg_tab[5] = '{1, $urandom_range(1, 65535), $urandom_range(0, 32'h4_0000),
                       $urandom_range(0, 32'h40_0000)};
        cfg_tab[6] = '{0, $urandom(), 0, $urandom_range(0, 32'h7FFF_FFFF)};

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].op, dir_rows[i].tx, dir_rows[i].ty, dir_rows[i].dt, got);
            if (dir_rows[i].chk && (got.x !== dir_rows[i].ex || got.y !== dir_rows[i].ey ||
                                    got.arrived !== dir_rows[i].ea)) begin
                $error("row %0d: x %h y %h arrived %0d, table says %h %h %0d", i,
                       got.x, got.y, got.arrived, dir_rows[i].ex, dir_rows[i].ey,
                       dir_rows[i].ea);
                errors++;
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            cfg_write(REG_SMOOTH, cfg_tab[p][0]);
            cfg_write(REG_SPEED, cfg_tab[p][1]);
            cfg_write(REG_SNAP, cfg_tab[p][2]);
            cfg_write(REG_DEAD, cfg_tab[p][3]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // alternate bursts with no idling on either side
                if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 99);
                op = (pick < 10);
                if (pick < 55) begin
                    // close to the current position: exercises snap, dead zone, clamp
                    k = $urandom_range(0, 30);
                    tx = trk_x + ($signed($urandom()) >>> (31 - k));
                    ty = trk_y + ($signed($urandom()) >>> (31 - k));
                end else begin
                    tx = $urandom();
                    ty = $urandom();
                end
                case ($urandom_range(0, 9))
                    0: dt = 16'h0;
                    1: dt = 16'hFFFF;
                    default: dt = $urandom();
                endcase
                send_item(op, tx, ty, dt, got);
            end
        end

        s_valid = 1'b0;
        no_idle = 0;
        while (pos_expect_q.size() != 0) @(negedge aclk);
        repeat (40) @(posedge aclk);
        $display("checked %0d result beats (%0d arrived) over %0d register settings",
                 n_results, n_arrived, N_PHASES + 1);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
